FILE: hw/rtl/tinyie_pkg.sv
// package for the tiny register machine execute block
// holds the request/result structs, opcodes and the register index table; no dependencies
`timescale 1ns / 1ps

package tinyie_pkg;

    localparam int NUM_REGS  = 16;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int DATA_W    = 64;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [DATA_W-1:0]    t_word;

    // opcodes
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_LDC   = 4'd1,
        OP_LDR   = 4'd2,
        OP_JMPC  = 4'd3,
        OP_JMPR  = 4'd4,
        OP_CJMPC = 4'd5,
        OP_CJMPR = 4'd6,
        OP_EQC   = 4'd7,
        OP_EQR   = 4'd8,
        OP_ADDC  = 4'd9,
        OP_ADDR  = 4'd10,
        OP_DBG   = 4'd11,
        OP_HALT  = 4'd12
    } t_op;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
        logic [7:0] arg_c;
    } t_req;

    typedef struct packed {
        t_word      next_ip;
        logic       halted;
        logic       debug_valid;
        logic [7:0] debug_index;
        t_word      debug_value;
    } t_res;

    // register file write
    typedef struct packed {
        logic     en;
        t_reg_idx idx;
        t_word    data;
    } t_wr;

    // three read addresses of one instruction
    typedef struct packed {
        t_reg_idx a;
        t_reg_idx b;
        t_reg_idx c;
    } t_rd_idx;

    // argument byte to register index, byte modulo register count
    typedef t_reg_idx t_sel_tab [256];

    function automatic t_sel_tab build_sel_tab();
        t_sel_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = t_reg_idx'(i % NUM_REGS);
        end
        return tab;
    endfunction

    localparam t_sel_tab SEL_TAB = build_sel_tab();

endpackage

FILE: hw/rtl/tiny_vm_instruction_execute.sv
// top level of the tiny register machine execute block
// depends on tinyie_pkg, tinyie_regfile and tinyie_exec
`timescale 1ns / 1ps

// executes one decoded instruction per request and returns one result per request:
// the new instruction pointer, the sticky halted flag and an optional debug read-out.
// throughput is one instruction per clock while results are not stalled; a request
// passes through the execute stage register, then the output register. the register
// file is read at the accept edge into registered read ports, and a bypass from the
// instruction retiring at that same edge keeps back-to-back dependent instructions
// correct. registers read as zero after reset through per-entry valid bits, so no
// clearing pass is needed. a stalled result stops requests only if execute is full.
module tiny_vm_instruction_execute
    import tinyie_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_stall,
    output t_res o_res
);

    // execute stage
    logic    r_s1_valid;
    t_req    r_s1;
    // architectural state
    t_word   r_ip;
    logic    r_halt;
    // output register
    logic    r_out_valid;
    t_res    r_out;

    logic    out_free;
    logic    s1_adv;
    logic    req_acc;
    t_rd_idx rd_idx;
    t_word   opa;
    t_word   opb;
    t_word   opc;
    t_wr     ex_wr;
    t_wr     rf_wr;
    t_res    ex_res;

    // handshake
    assign out_free    = !r_out_valid || !i_res_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_req_stall = r_s1_valid && !out_free;
    assign req_acc     = i_req_valid && !o_req_stall;

    // register indices of the incoming request
    assign rd_idx.a = SEL_TAB[i_req.arg_a];
    assign rd_idx.b = SEL_TAB[i_req.arg_b];
    assign rd_idx.c = SEL_TAB[i_req.arg_c];

    // a write commits only when the instruction retires
    always_comb begin
        rf_wr    = ex_wr;
        rf_wr.en = ex_wr.en && s1_adv;
    end

    tinyie_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (req_acc),
        .i_rd_idx (rd_idx),
        .i_wr     (rf_wr),
        .o_opa    (opa),
        .o_opb    (opb),
        .o_opc    (opc)
    );

    tinyie_exec u_exec (
        .i_instr (r_s1),
        .i_opa   (opa),
        .i_opb   (opb),
        .i_opc   (opc),
        .i_ip    (r_ip),
        .i_halt  (r_halt),
        .o_wr    (ex_wr),
        .o_res   (ex_res)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1 <= i_req;
        end
        if (s1_adv) begin
            r_out <= ex_res;
        end
    end

    // control and machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ip        <= '0;
            r_halt      <= 1'b0;
        end else begin
            if (req_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_ip        <= ex_res.next_ip;
                r_halt      <= ex_res.halted;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

FILE: hw/rtl/tinyie_regfile.sv
// register file of the tiny register machine: two memory copies, valid bits and bypass
// depends on tinyie_pkg
`timescale 1ns / 1ps

module tinyie_regfile
    import tinyie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rd_en,
    input  t_rd_idx i_rd_idx,
    input  t_wr     i_wr,
    output t_word   o_opa,
    output t_word   o_opb,
    output t_word   o_opc
);

    t_word                r_mem0 [NUM_REGS];
    t_word                r_mem1 [NUM_REGS];
    logic [NUM_REGS-1:0]  r_vld;
    t_word                r_rd_a;
    t_word                r_rd_b;
    t_word                r_rd_c;
    logic [2:0]           r_rdv;
    t_rd_idx              r_idx;
    logic                 r_fwd_en;
    t_reg_idx             r_fwd_idx;
    t_word                r_fwd_data;

    // memories, copy 0 serves ports a and b, copy 1 serves port c
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem0[i_wr.idx] <= i_wr.data;
            r_mem1[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem0[i_rd_idx.a];
            r_rd_b <= r_mem0[i_rd_idx.b];
            r_rd_c <= r_mem1[i_rd_idx.c];
            r_idx  <= i_rd_idx;
        end
        if (i_wr.en) begin
            r_fwd_idx  <= i_wr.idx;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rdv    <= '0;
            r_fwd_en <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rdv <= {r_vld[i_rd_idx.c], r_vld[i_rd_idx.b], r_vld[i_rd_idx.a]};
            end
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
                r_fwd_en        <= 1'b1;
            end
        end
    end

    // latest write wins over the memory, unwritten entries read zero
    assign o_opa = (r_fwd_en && (r_fwd_idx == r_idx.a)) ? r_fwd_data
                 : (r_rdv[0] ? r_rd_a : '0);
    assign o_opb = (r_fwd_en && (r_fwd_idx == r_idx.b)) ? r_fwd_data
                 : (r_rdv[1] ? r_rd_b : '0);
    assign o_opc = (r_fwd_en && (r_fwd_idx == r_idx.c)) ? r_fwd_data
                 : (r_rdv[2] ? r_rd_c : '0);

endmodule

FILE: hw/rtl/tinyie_exec.sv
// execute logic of the tiny register machine: next ip, register write and result fields
// depends on tinyie_pkg
`timescale 1ns / 1ps

module tinyie_exec
    import tinyie_pkg::*;
(
    input  t_req  i_instr,
    input  t_word i_opa,
    input  t_word i_opb,
    input  t_word i_opc,
    input  t_word i_ip,
    input  logic  i_halt,
    output t_wr   o_wr,
    output t_res  o_res
);

    function automatic t_word sext8(logic [7:0] v);
        return {{(DATA_W-8){v[7]}}, v};
    endfunction

    function automatic t_word sext32(t_word v);
        return {{(DATA_W-32){v[31]}}, v[31:0]};
    endfunction

    always_comb begin
        o_wr              = '0;
        o_wr.idx          = SEL_TAB[i_instr.arg_a];
        o_res             = '0;
        o_res.next_ip     = i_ip + t_word'(1);
        o_res.halted      = i_halt;
        case (i_instr.kind)
            OP_NOP: begin
            end
            OP_LDC: begin
                o_wr.en   = 1'b1;
                o_wr.data = t_word'(i_instr.arg_b);
            end
            OP_LDR: begin
                o_wr.en   = 1'b1;
                o_wr.data = i_opb;
            end
            OP_JMPC: begin
                o_res.next_ip = i_ip + t_word'(i_instr.arg_a);
            end
            OP_JMPR: begin
                o_res.next_ip = i_ip + sext32(i_opa);
            end
            OP_CJMPC: begin
                o_res.next_ip = i_ip + ((i_opa != '0) ? sext8(i_instr.arg_b)
                                                      : sext8(i_instr.arg_c));
            end
            OP_CJMPR: begin
                o_res.next_ip = i_ip + sext32((i_opa != '0) ? i_opb : i_opc);
            end
            OP_EQC: begin
                o_wr.en   = 1'b1;
                o_wr.data = t_word'(i_opb == t_word'(i_instr.arg_c));
            end
            OP_EQR: begin
                o_wr.en   = 1'b1;
                o_wr.data = t_word'(i_opb == i_opc);
            end
            OP_ADDC: begin
                o_wr.en   = 1'b1;
                o_wr.data = i_opb + t_word'(i_instr.arg_c);
            end
            OP_ADDR: begin
                o_wr.en   = 1'b1;
                o_wr.data = i_opb + i_opc;
            end
            OP_DBG: begin
                o_res.debug_valid = 1'b1;
                o_res.debug_index = i_instr.arg_a;
                o_res.debug_value = i_opa;
            end
            OP_HALT: begin
                o_res.halted  = 1'b1;
                o_res.next_ip = i_ip;
            end
            default: begin
                // unused opcodes leave everything unchanged
                o_res.next_ip = i_ip;
            end
        endcase
    end

endmodule
